// ===== design/c8alu_pkg.sv =====
package c8alu_pkg;

	typedef enum logic [3:0] {
		ACT_ADD   = 4'd0,
		ACT_ADC   = 4'd1,
		ACT_SUB   = 4'd2,
		ACT_SBC   = 4'd3,
		ACT_LDA   = 4'd4,
		ACT_LDX   = 4'd5,
		ACT_STA   = 4'd6,
		ACT_INC   = 4'd7,
		ACT_DEC   = 4'd8,
		ACT_NEG   = 4'd9,
		ACT_MUL   = 4'd10,
		ACT_DIV   = 4'd11,
		ACT_CLC   = 4'd12,
		ACT_SEC   = 4'd13,
		ACT_NOP   = 4'd14,
		ACT_SPARE = 4'd15
	} action_t;

	localparam logic [1:0] TGT_ACC   = 2'd0;
	localparam logic [1:0] TGT_XL    = 2'd1;
	localparam logic [1:0] TGT_MEM   = 2'd2;
	localparam logic [1:0] TGT_SPARE = 2'd3;

	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic exec;
		logic div_start;
		logic div_step;
		logic div_last;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_div;
		logic div_zero;
	} status_t;

endpackage

// ===== design/c8alu_ctrl.sv =====
module c8alu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  c8alu_pkg::status_t  status,
	output c8alu_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	localparam logic [c8alu_pkg::CNT_W-1:0] LastStep =
		c8alu_pkg::CNT_W'(c8alu_pkg::DIV_STEPS - 1);

	state_t                      state_q, state_n;
	logic [c8alu_pkg::CNT_W-1:0] count_q;
	logic                        out_valid_q;
	logic                        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (status.is_div && !status.div_zero) begin
						cmd.div_start = 1'b1;
						state_n       = S_DIV;
					end else begin
						cmd.exec = 1'b1;
						state_n  = S_HOLD;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = (count_q == LastStep);
				if (count_q == LastStep) begin
					state_n = S_HOLD;
				end
			end
			S_HOLD: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.div_start) begin
				count_q <= '0;
			end else if (cmd.div_step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("Controller state is not one-hot.");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == S_DIV) && (count_q == '0))
		else $error("Divide did not start from step zero.");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (count_q == LastStep) |=> (state_q == S_HOLD))
		else $error("Divide did not finish after its last step.");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("Output word loaded without valid.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("Output word overwritten before it was taken.");
`endif

endmodule

// ===== design/c8alu_dp.sv =====
module c8alu_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          action,
	input  logic [7:0]          operand,
	input  logic [1:0]          rmw_target,
	input  c8alu_pkg::cmd_t     cmd,
	output c8alu_pkg::status_t  status,
	output logic [7:0]          acc_out,
	output logic [7:0]          idx_low_out,
	output logic [7:0]          idx_high_out,
	output logic                flag_v,
	output logic                flag_h,
	output logic                flag_n,
	output logic                flag_z,
	output logic                flag_c,
	output logic [7:0]          store_data,
	output logic                store_valid
);

	logic [7:0]  acc_q, xl_q, xh_q;
	logic        v_q, h_q, n_q, z_q, c_q;
	logic [7:0]  sd_q;
	logic        sv_q;

	logic [7:0]  acc_n, xl_n, xh_n;
	logic        v_n, h_n, n_n, z_n, c_n;
	logic [7:0]  sd_n;
	logic        sv_n;

	logic        cin;
	logic [7:0]  add_r, sub_r, old, rmw_r;
	logic [15:0] prod;
	logic        a7, m7, a3, m3;

	logic [7:0]  div_rem_q;
	logic [15:0] div_num_q;
	logic [8:0]  trial;
	logic        div_ge;
	logic [7:0]  rem_n;
	logic [15:0] num_n;

	logic [7:0]  o_acc_q, o_xl_q, o_xh_q, o_sd_q;
	logic        o_v_q, o_h_q, o_n_q, o_z_q, o_c_q, o_sv_q;

	assign status.is_div   = (action == c8alu_pkg::ACT_DIV);
	assign status.div_zero = (xl_q == 8'h00);

	assign cin = ((action == c8alu_pkg::ACT_ADC) || (action == c8alu_pkg::ACT_SBC)) ? c_q : 1'b0;
	assign add_r = acc_q + operand + {7'd0, cin};
	assign sub_r = acc_q - operand - {7'd0, cin};
	assign prod  = 16'(acc_q) * 16'(xl_q);
	assign a7 = acc_q[7];
	assign m7 = operand[7];
	assign a3 = acc_q[3];
	assign m3 = operand[3];

	always_comb begin
		if (rmw_target == c8alu_pkg::TGT_ACC) begin
			old = acc_q;
		end else if (rmw_target == c8alu_pkg::TGT_XL) begin
			old = xl_q;
		end else begin
			old = operand;
		end
	end

	always_comb begin
		acc_n = acc_q;
		xl_n  = xl_q;
		xh_n  = xh_q;
		v_n   = v_q;
		h_n   = h_q;
		n_n   = n_q;
		z_n   = z_q;
		c_n   = c_q;
		sd_n  = 8'h00;
		sv_n  = 1'b0;
		rmw_r = 8'h00;
		unique case (action)
			c8alu_pkg::ACT_ADD, c8alu_pkg::ACT_ADC: begin
				acc_n = add_r;
				v_n   = (a7 && m7 && !add_r[7]) || (!a7 && !m7 && add_r[7]);
				h_n   = (a3 && m3) || (m3 && !add_r[3]) || (!add_r[3] && a3);
				c_n   = (a7 && m7) || (m7 && !add_r[7]) || (!add_r[7] && a7);
				n_n   = add_r[7];
				z_n   = (add_r == 8'h00);
			end
			c8alu_pkg::ACT_SUB, c8alu_pkg::ACT_SBC: begin
				acc_n = sub_r;
				v_n   = (a7 && !m7 && !sub_r[7]) || (!a7 && m7 && sub_r[7]);
				c_n   = (!a7 && m7) || (m7 && sub_r[7]) || (sub_r[7] && !a7);
				n_n   = sub_r[7];
				z_n   = (sub_r == 8'h00);
			end
			c8alu_pkg::ACT_LDA: begin
				acc_n = operand;
				v_n   = 1'b0;
				n_n   = operand[7];
				z_n   = (operand == 8'h00);
			end
			c8alu_pkg::ACT_LDX: begin
				xl_n = operand;
				v_n  = 1'b0;
				n_n  = operand[7];
				z_n  = (operand == 8'h00);
			end
			c8alu_pkg::ACT_STA: begin
				sd_n = acc_q;
				sv_n = 1'b1;
				v_n  = 1'b0;
				n_n  = acc_q[7];
				z_n  = (acc_q == 8'h00);
			end
			c8alu_pkg::ACT_INC, c8alu_pkg::ACT_DEC, c8alu_pkg::ACT_NEG: begin
				if (action == c8alu_pkg::ACT_INC) begin
					rmw_r = old + 8'd1;
					v_n   = (old == 8'h7F);
				end else if (action == c8alu_pkg::ACT_DEC) begin
					rmw_r = old - 8'd1;
					v_n   = (old == 8'h80);
				end else begin
					rmw_r = 8'd0 - old;
					c_n   = (old != 8'h00);
					v_n   = rmw_r[7] && old[7];
				end
				n_n = rmw_r[7];
				z_n = (rmw_r == 8'h00);
				if (rmw_target == c8alu_pkg::TGT_ACC) begin
					acc_n = rmw_r;
				end else if (rmw_target == c8alu_pkg::TGT_XL) begin
					xl_n = rmw_r;
				end else begin
					sd_n = rmw_r;
					sv_n = 1'b1;
				end
			end
			c8alu_pkg::ACT_MUL: begin
				acc_n = prod[7:0];
				xl_n  = prod[15:8];
				c_n   = 1'b0;
				h_n   = 1'b0;
			end
			c8alu_pkg::ACT_DIV: begin
				// Only reached here for a zero divisor.
				c_n = 1'b1;
			end
			c8alu_pkg::ACT_CLC: begin
				c_n = 1'b0;
			end
			c8alu_pkg::ACT_SEC: begin
				c_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign trial  = {div_rem_q, div_num_q[15]};
	assign div_ge = (trial >= {1'b0, xl_q});
	assign rem_n  = div_ge ? 8'(trial - {1'b0, xl_q}) : trial[7:0];
	assign num_n  = {div_num_q[14:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'h00;
			xl_q  <= 8'h00;
			xh_q  <= 8'h00;
			v_q   <= 1'b0;
			h_q   <= 1'b0;
			n_q   <= 1'b0;
			z_q   <= 1'b0;
			c_q   <= 1'b0;
			sd_q  <= 8'h00;
			sv_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				acc_q <= acc_n;
				xl_q  <= xl_n;
				xh_q  <= xh_n;
				v_q   <= v_n;
				h_q   <= h_n;
				n_q   <= n_n;
				z_q   <= z_n;
				c_q   <= c_n;
				sd_q  <= sd_n;
				sv_q  <= sv_n;
			end else if (cmd.div_start) begin
				sd_q <= 8'h00;
				sv_q <= 1'b0;
			end else if (cmd.div_step && cmd.div_last) begin
				acc_q <= num_n[7:0];
				xh_q  <= rem_n;
				c_q   <= (num_n[15:8] != 8'h00);
				z_q   <= (num_n[7:0] == 8'h00);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= 8'h00;
			div_num_q <= {xh_q, acc_q};
		end else if (cmd.div_step) begin
			div_rem_q <= rem_n;
			div_num_q <= num_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_acc_q <= acc_q;
			o_xl_q  <= xl_q;
			o_xh_q  <= xh_q;
			o_v_q   <= v_q;
			o_h_q   <= h_q;
			o_n_q   <= n_q;
			o_z_q   <= z_q;
			o_c_q   <= c_q;
			o_sd_q  <= sd_q;
			o_sv_q  <= sv_q;
		end
	end

	assign acc_out      = o_acc_q;
	assign idx_low_out  = o_xl_q;
	assign idx_high_out = o_xh_q;
	assign flag_v       = o_v_q;
	assign flag_h       = o_h_q;
	assign flag_n       = o_n_q;
	assign flag_z       = o_z_q;
	assign flag_c       = o_c_q;
	assign store_data   = o_sd_q;
	assign store_valid  = o_sv_q;

endmodule

// ===== design/cpu8_alu_flag_execute_top.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  action, operand, rmw_target
// output    out        out_valid / out_ready acc_out, idx_low_out, idx_high_out,
//                                           flag_v/h/n/z/c, store_data, store_valid
//
// A word other than DIV with a nonzero divisor executes, then goes to the output register.
// DIV with a nonzero divisor goes through the 16-step one-bit restoring divider instead.
// A new word is accepted while the previous result still waits in the output register.
// Reset clears A, X and the flags; the output register stays empty until the first result.
// A stalled output holds the next finished result inside the block and stops input.
module cpu8_alu_flag_execute_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] action,
	input  logic [7:0] operand,
	input  logic [1:0] rmw_target,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] acc_out,
	output logic [7:0] idx_low_out,
	output logic [7:0] idx_high_out,
	output logic       flag_v,
	output logic       flag_h,
	output logic       flag_n,
	output logic       flag_z,
	output logic       flag_c,
	output logic [7:0] store_data,
	output logic       store_valid
);

	c8alu_pkg::cmd_t    cmd;
	c8alu_pkg::status_t status;

	c8alu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	c8alu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (action),
		.operand      (operand),
		.rmw_target   (rmw_target),
		.cmd          (cmd),
		.status       (status),
		.acc_out      (acc_out),
		.idx_low_out  (idx_low_out),
		.idx_high_out (idx_high_out),
		.flag_v       (flag_v),
		.flag_h       (flag_h),
		.flag_n       (flag_n),
		.flag_z       (flag_z),
		.flag_c       (flag_c),
		.store_data   (store_data),
		.store_valid  (store_valid)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] xl;
		logic [7:0] xh;
		logic       v;
		logic       h;
		logic       n;
		logic       z;
		logic       c;
		logic [7:0] sdata;
		logic       svalid;
	} alu_word_t;

	class alu_state_board;
		logic [7:0] acc;
		logic [7:0] xl;
		logic [7:0] xh;
		logic fv, fh, fn, fz, fc;
		alu_word_t state_after[$];
		int errors;

		function new();
			acc = 8'h00;
			xl = 8'h00;
			xh = 8'h00;
			fv = 1'b0;
			fh = 1'b0;
			fn = 1'b0;
			fz = 1'b0;
			fc = 1'b0;
			errors = 0;
		endfunction

		function void issue_word(logic [3:0] act, logic [7:0] m, logic [1:0] tgt);
			logic [7:0] a, r, old;
			logic [15:0] num, prod, quo, rem;
			logic cin, a7, m7, r7, a3, m3, r3;
			alu_word_t w;
			a = acc;
			cin = fc;
			a7 = a[7];
			m7 = m[7];
			a3 = a[3];
			m3 = m[3];
			w = '0;
			case (act)
				c8alu_pkg::ACT_ADD, c8alu_pkg::ACT_ADC: begin
					r = a + m + {7'd0, cin & (act == c8alu_pkg::ACT_ADC)};
					r7 = r[7];
					r3 = r[3];
					fv = (a7 & m7 & ~r7) | (~a7 & ~m7 & r7);
					fh = (a3 & m3) | (m3 & ~r3) | (~r3 & a3);
					fc = (a7 & m7) | (m7 & ~r7) | (~r7 & a7);
					fn = r7;
					fz = (r == 8'h00);
					acc = r;
				end
				c8alu_pkg::ACT_SUB, c8alu_pkg::ACT_SBC: begin
					r = a - m - {7'd0, cin & (act == c8alu_pkg::ACT_SBC)};
					r7 = r[7];
					fv = (a7 & ~m7 & ~r7) | (~a7 & m7 & r7);
					fc = (~a7 & m7) | (m7 & r7) | (r7 & ~a7);
					fn = r7;
					fz = (r == 8'h00);
					acc = r;
				end
				c8alu_pkg::ACT_LDA: begin
					acc = m;
					fv = 1'b0;
					fn = m[7];
					fz = (m == 8'h00);
				end
				c8alu_pkg::ACT_LDX: begin
					xl = m;
					fv = 1'b0;
					fn = m[7];
					fz = (m == 8'h00);
				end
				c8alu_pkg::ACT_STA: begin
					w.sdata = acc;
					w.svalid = 1'b1;
					fv = 1'b0;
					fn = acc[7];
					fz = (acc == 8'h00);
				end
				c8alu_pkg::ACT_INC, c8alu_pkg::ACT_DEC, c8alu_pkg::ACT_NEG: begin
					old = (tgt == c8alu_pkg::TGT_ACC) ? acc :
						(tgt == c8alu_pkg::TGT_XL) ? xl : m;
					if (act == c8alu_pkg::ACT_INC) begin
						r = old + 8'd1;
						fv = (old == 8'h7F);
					end else if (act == c8alu_pkg::ACT_DEC) begin
						r = old - 8'd1;
						fv = (old == 8'h80);
					end else begin
						r = 8'd0 - old;
						fc = (old != 8'h00);
						fv = r[7] & old[7];
					end
					fn = r[7];
					fz = (r == 8'h00);
					if (tgt == c8alu_pkg::TGT_ACC) begin
						acc = r;
					end else if (tgt == c8alu_pkg::TGT_XL) begin
						xl = r;
					end else begin
						w.sdata = r;
						w.svalid = 1'b1;
					end
				end
				c8alu_pkg::ACT_MUL: begin
					prod = {8'd0, acc} * {8'd0, xl};
					acc = prod[7:0];
					xl = prod[15:8];
					fc = 1'b0;
					fh = 1'b0;
				end
				c8alu_pkg::ACT_DIV: begin
					if (xl == 8'h00) begin
						fc = 1'b1;
					end else begin
						num = {xh, acc};
						quo = num / {8'd0, xl};
						rem = num % {8'd0, xl};
						acc = quo[7:0];
						xh = rem[7:0];
						fc = (quo > 16'h00FF);
						fz = (acc == 8'h00);
					end
				end
				c8alu_pkg::ACT_CLC: fc = 1'b0;
				c8alu_pkg::ACT_SEC: fc = 1'b1;
				default: ;
			endcase
			w.acc = acc;
			w.xl = xl;
			w.xh = xh;
			w.v = fv;
			w.h = fh;
			w.n = fn;
			w.z = fz;
			w.c = fc;
			state_after.push_back(w);
		endfunction

		function void compare(string name, logic [7:0] want_v, logic [7:0] got_v);
			if (want_v !== got_v) begin
				$error("%s: expected %0h, got %0h", name, want_v, got_v);
				errors++;
			end
		endfunction

		function void retire_word(alu_word_t got);
			alu_word_t want;
			if (state_after.size() == 0) begin
				$error("result word arrived with no expected word pending");
				errors++;
				return;
			end
			want = state_after.pop_front();
			compare("acc_out", want.acc, got.acc);
			compare("idx_low_out", want.xl, got.xl);
			compare("idx_high_out", want.xh, got.xh);
			compare("flag_v", {7'd0, want.v}, {7'd0, got.v});
			compare("flag_h", {7'd0, want.h}, {7'd0, got.h});
			compare("flag_n", {7'd0, want.n}, {7'd0, got.n});
			compare("flag_z", {7'd0, want.z}, {7'd0, got.z});
			compare("flag_c", {7'd0, want.c}, {7'd0, got.c});
			compare("store_data", want.sdata, got.sdata);
			compare("store_valid", {7'd0, want.svalid}, {7'd0, got.svalid});
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [3:0] action;
	logic [7:0] operand;
	logic [1:0] rmw_target;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] acc_out;
	logic [7:0] idx_low_out;
	logic [7:0] idx_high_out;
	logic       flag_v;
	logic       flag_h;
	logic       flag_n;
	logic       flag_z;
	logic       flag_c;
	logic [7:0] store_data;
	logic       store_valid;

	logic       steady;
	alu_word_t  seen;
	alu_state_board board = new();

	cpu8_alu_flag_execute_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.operand      (operand),
		.rmw_target   (rmw_target),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.acc_out      (acc_out),
		.idx_low_out  (idx_low_out),
		.idx_high_out (idx_high_out),
		.flag_v       (flag_v),
		.flag_h       (flag_h),
		.flag_n       (flag_n),
		.flag_z       (flag_z),
		.flag_c       (flag_c),
		.store_data   (store_data),
		.store_valid  (store_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.issue_word(action, operand, rmw_target);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {acc_out, idx_low_out, idx_high_out, flag_v, flag_h, flag_n,
				flag_z, flag_c, store_data, store_valid};
			board.retire_word(seen);
		end
		out_ready <= steady || ($urandom_range(99) >= 37);
	end

	task automatic send_word(input logic [3:0] act, input logic [7:0] m,
			input logic [1:0] tgt);
		while (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		operand <= m;
		rmw_target <= tgt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		logic [3:0] act;
		logic [7:0] m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = c8alu_pkg::ACT_ADD;
		operand = 8'h00;
		rmw_target = c8alu_pkg::TGT_ACC;
		out_ready = 1'b0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(c8alu_pkg::ACT_LDA, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDA, 8'h80, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDA, 8'h7F, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_ADD, 8'h01, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_ADC, 8'hFF, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_SEC, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_ADC, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_SUB, 8'h80, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_SBC, 8'hFF, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_CLC, 8'hFF, c8alu_pkg::TGT_SPARE);
		send_word(c8alu_pkg::ACT_SBC, 8'h01, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_STA, 8'h55, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDX, 8'h7F, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_INC, 8'h00, c8alu_pkg::TGT_XL);
		send_word(c8alu_pkg::ACT_DEC, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_NEG, 8'h80, c8alu_pkg::TGT_MEM);
		send_word(c8alu_pkg::ACT_NEG, 8'h00, c8alu_pkg::TGT_SPARE);
		send_word(c8alu_pkg::ACT_INC, 8'hFF, c8alu_pkg::TGT_MEM);
		send_word(c8alu_pkg::ACT_DEC, 8'h80, c8alu_pkg::TGT_MEM);
		send_word(c8alu_pkg::ACT_MUL, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDX, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_DIV, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDA, 8'hFF, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDX, 8'hC8, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_DIV, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_LDX, 8'h02, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_DIV, 8'h00, c8alu_pkg::TGT_ACC);
		send_word(c8alu_pkg::ACT_SPARE, 8'hAA, c8alu_pkg::TGT_XL);
		send_word(c8alu_pkg::ACT_NOP, 8'h00, c8alu_pkg::TGT_ACC);

		for (int i = 0; i < 750; i++) begin
			steady = (i >= 300 && i < 420);
			act = 4'($urandom_range(15));
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(4))
					0: m = 8'h00;
					1: m = 8'h7F;
					2: m = 8'h80;
					3: m = 8'hFF;
					default: m = 8'h01;
				endcase
			end else begin
				m = 8'($urandom_range(255));
			end
			send_word(act, m, 2'($urandom_range(3)));
		end
		steady = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);

		while (board.state_after.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
